FILE: rtl/mfep_pkg.sv
// Package: shared types, constants and phase codes for the MIDI file event parser.
`default_nettype none
package mfep_pkg;

    localparam int VARINT_MAX_BYTES_DEF = 4;
    localparam int CHUNK_LEN_BITS_DEF   = 32;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_CHANNEL = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_SYSF0   = 3'd3;
    localparam logic [2:0] KIND_SYSF7   = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [7:0] ERR_HDR_ID   = 8'd0;
    localparam logic [7:0] ERR_HDR_LEN  = 8'd1;
    localparam logic [7:0] ERR_SMPTE    = 8'd2;
    localparam logic [7:0] ERR_TRK_ID   = 8'd3;
    localparam logic [7:0] ERR_META_LEN = 8'd4;
    localparam logic [7:0] ERR_STATUS   = 8'd5;
    localparam logic [7:0] ERR_VARINT   = 8'd6;
    localparam logic [7:0] ERR_FRAMING  = 8'd7;

    localparam logic [7:0] META_SEQ    = 8'h00;
    localparam logic [7:0] META_CHPFX  = 8'h20;
    localparam logic [7:0] META_EOT    = 8'h2f;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_SMPTE  = 8'h54;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG = 8'h59;
    localparam logic [7:0] STAT_META   = 8'hff;
    localparam logic [7:0] STAT_SYSF0  = 8'hf0;
    localparam logic [7:0] STAT_SYSF7  = 8'hf7;

    localparam logic [31:0] ID_MTHD = 32'h4D546864;
    localparam logic [31:0] ID_MTRK = 32'h4D54726B;
    localparam logic [27:0] SAT28   = 28'hFFFFFFF;

    typedef enum logic [4:0] {
        PH_HDR_ID, PH_HDR_LEN, PH_HDR_BODY, PH_TRK_ID, PH_TRK_LEN, PH_DELTA,
        PH_STATUS, PH_CH_P1, PH_CH_P2, PH_META_TYPE, PH_META_LEN, PH_META_FIXED,
        PH_SYSEX_LEN, PH_PAYLOAD, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  subtype;
        logic [3:0]  channel_number;
        logic [15:0] track_number;
        logic [27:0] delta_ticks;
        logic [23:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [7:0]  value_d;
        logic [15:0] value_e;
        logic [27:0] payload_length;
        logic        last_of_event;
    } rec_t;

    // Required byte count of a fixed-size meta event, -1 when not fixed.
    function automatic logic signed [3:0] fixed_len(input logic [7:0] t);
        case (t)
            META_SEQ:     fixed_len = 4'sd2;
            META_CHPFX:   fixed_len = 4'sd1;
            META_EOT:     fixed_len = 4'sd0;
            META_TEMPO:   fixed_len = 4'sd3;
            META_SMPTE:   fixed_len = 4'sd5;
            META_TIMESIG: fixed_len = 4'sd4;
            META_KEYSIG:  fixed_len = 4'sd2;
            default:      fixed_len = -4'sd1;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mfep_if.sv
// Interfaces: valid/ready channels for input bytes and result records.
`default_nettype none
interface mfep_in_if;
    logic                 valid;
    logic                 ready;
    mfep_pkg::in_item_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mfep_out_if;
    logic             valid;
    logic             ready;
    mfep_pkg::rec_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/mfep_core.sv
// Parser core: state registers and one-byte next-state and record logic.
`default_nettype none
module mfep_core #(
    parameter int VARINT_MAX_BYTES = mfep_pkg::VARINT_MAX_BYTES_DEF,
    parameter int CHUNK_LEN_BITS   = mfep_pkg::CHUNK_LEN_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              final_byte,
    output logic                   rec_valid,
    output mfep_pkg::rec_t         rec
);
    localparam int VCW = $clog2(VARINT_MAX_BYTES + 1);

    mfep_pkg::phase_t   phase_reg, phase_next;
    logic [2:0]         fpos_reg, fpos_next;
    logic [27:0]        vacc_reg, vacc_next;
    logic [VCW-1:0]     vcnt_reg, vcnt_next;
    logic [31:0]        cleft_reg, cleft_next;
    logic [7:0]         rstat_reg, rstat_next;
    logic               rsv_reg, rsv_next;
    logic [15:0]        texp_reg, texp_next;
    logic [15:0]        tdone_reg, tdone_next;
    logic [27:0]        pdelta_reg, pdelta_next;
    logic [7:0]         mtype_reg, mtype_next;
    logic [27:0]        pleft_reg, pleft_next;
    logic [47:0]        fbuf_reg, fbuf_next;
    logic               err_reg, err_next;

    logic [47:0]        shifted;
    logic [2:0]         pos_inc;
    logic [34:0]        vwide;
    logic [27:0]        vsat;
    logic [VCW-1:0]     vcnt_inc;
    logic               vdone, vlong;
    logic [31:0]        cdec;
    logic [3:0]         ctype;
    logic [7:0]         p1, p2;
    logic               is_chan;
    logic [7:0]         dexp;
    logic signed [3:0]  need;
    logic [3:0]         pos4;
    logic               in_track;

    always_comb
    begin
        shifted  = {fbuf_reg[39:0], data_byte};
        pos_inc  = fpos_reg + 3'd1;
        vwide    = {vacc_reg, data_byte[6:0]};
        vsat     = (vwide[34:28] != 7'd0) ? mfep_pkg::SAT28 : vwide[27:0];
        vcnt_inc = vcnt_reg + VCW'(1);
        vdone    = !data_byte[7];
        vlong    = data_byte[7] && (int'(vcnt_inc) >= VARINT_MAX_BYTES);
        cdec     = cleft_reg - 32'd1;
        ctype    = rstat_reg[7:4];
        need     = mfep_pkg::fixed_len(mtype_reg);
        pos4     = {1'b0, pos_inc};
        in_track = 1'b0;
        p1 = 8'd0;
        p2 = 8'd0;
        is_chan = 1'b0;
        dexp = 8'd0;

        phase_next = phase_reg;  fpos_next = fpos_reg;   vacc_next = vacc_reg;
        vcnt_next = vcnt_reg;    cleft_next = cleft_reg; rstat_next = rstat_reg;
        rsv_next = rsv_reg;      texp_next = texp_reg;   tdone_next = tdone_reg;
        pdelta_next = pdelta_reg; mtype_next = mtype_reg; pleft_next = pleft_reg;
        fbuf_next = fbuf_reg;    err_next = err_reg;

        rec_valid = 1'b0;
        rec = '0;
        rec.track_number  = tdone_reg;
        rec.delta_ticks   = pdelta_reg;
        rec.last_of_event = 1'b1;

        if (step && !err_reg)
        begin
            unique case (phase_reg)
                mfep_pkg::PH_HDR_ID, mfep_pkg::PH_HDR_LEN, mfep_pkg::PH_TRK_ID:
                begin
                    fbuf_next = shifted;
                    fpos_next = pos_inc;
                    if (pos_inc == 3'd4)
                    begin
                        fpos_next = '0;
                        fbuf_next = '0;
                        if (phase_reg == mfep_pkg::PH_HDR_ID)
                        begin
                            if (shifted[31:0] != mfep_pkg::ID_MTHD)
                            begin
                                err_next = 1'b1; rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_ERROR;
                                rec.subtype = mfep_pkg::ERR_HDR_ID;
                                rec.delta_ticks = '0;
                            end
                            else
                                phase_next = mfep_pkg::PH_HDR_LEN;
                        end
                        else if (phase_reg == mfep_pkg::PH_HDR_LEN)
                        begin
                            if (shifted[31:0] != 32'd6)
                            begin
                                err_next = 1'b1; rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_ERROR;
                                rec.subtype = mfep_pkg::ERR_HDR_LEN;
                                rec.delta_ticks = '0;
                            end
                            else
                                phase_next = mfep_pkg::PH_HDR_BODY;
                        end
                        else
                        begin
                            if (shifted[31:0] != mfep_pkg::ID_MTRK)
                            begin
                                err_next = 1'b1; rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_ERROR;
                                rec.subtype = mfep_pkg::ERR_TRK_ID;
                                rec.delta_ticks = '0;
                            end
                            else
                                phase_next = mfep_pkg::PH_TRK_LEN;
                        end
                    end
                end
                mfep_pkg::PH_HDR_BODY:
                begin
                    fbuf_next = shifted;
                    fpos_next = pos_inc;
                    if (pos_inc == 3'd6)
                    begin
                        rec_valid = 1'b1;
                        if (shifted[15])
                        begin
                            err_next = 1'b1;
                            rec.record_kind = mfep_pkg::KIND_ERROR;
                            rec.subtype = mfep_pkg::ERR_SMPTE;
                            rec.delta_ticks = '0;
                        end
                        else
                        begin
                            rec.record_kind = mfep_pkg::KIND_HEADER;
                            rec.track_number = '0;
                            rec.delta_ticks = '0;
                            rec.value_a = {8'd0, shifted[47:32]};
                            rec.value_b = shifted[31:16];
                            rec.value_c = shifted[15:0];
                            texp_next = shifted[31:16];
                            tdone_next = '0;
                            fpos_next = '0;
                            fbuf_next = '0;
                            phase_next = (shifted[31:16] == 16'd0) ? mfep_pkg::PH_DONE
                                                                   : mfep_pkg::PH_TRK_ID;
                        end
                    end
                end
                mfep_pkg::PH_TRK_LEN:
                begin
                    fbuf_next = shifted;
                    fpos_next = pos_inc;
                    if (pos_inc == 3'd4)
                    begin
                        if (CHUNK_LEN_BITS < 32 &&
                            (shifted[31:0] >> CHUNK_LEN_BITS) != 32'd0)
                        begin
                            err_next = 1'b1; rec_valid = 1'b1;
                            rec.record_kind = mfep_pkg::KIND_ERROR;
                            rec.subtype = mfep_pkg::ERR_FRAMING;
                            rec.delta_ticks = '0;
                        end
                        else
                        begin
                            cleft_next = shifted[31:0];
                            rsv_next = 1'b0;
                            fpos_next = '0;
                            fbuf_next = '0;
                            if (shifted[31:0] == 32'd0)
                            begin
                                tdone_next = tdone_reg + 16'd1;
                                phase_next = (tdone_next == texp_reg) ? mfep_pkg::PH_DONE
                                                                     : mfep_pkg::PH_TRK_ID;
                            end
                            else
                            begin
                                phase_next = mfep_pkg::PH_DELTA;
                                vacc_next = '0;
                                vcnt_next = '0;
                            end
                        end
                    end
                end
                mfep_pkg::PH_DONE:
                begin
                end
                default:
                begin
                    in_track = 1'b1;
                    cleft_next = cdec;
                    case (phase_reg)
                        mfep_pkg::PH_DELTA, mfep_pkg::PH_META_LEN,
                        mfep_pkg::PH_SYSEX_LEN:
                        begin
                            vacc_next = vsat;
                            vcnt_next = vcnt_inc;
                            if (vdone)
                            begin
                                vcnt_next = '0;
                                vacc_next = '0;
                                if (phase_reg == mfep_pkg::PH_DELTA)
                                begin
                                    pdelta_next = vsat;
                                    phase_next = mfep_pkg::PH_STATUS;
                                end
                                else if (phase_reg == mfep_pkg::PH_SYSEX_LEN ||
                                         need < 0)
                                begin
                                    rec_valid = 1'b1;
                                    rec.record_kind = (phase_reg == mfep_pkg::PH_META_LEN)
                                        ? mfep_pkg::KIND_META
                                        : ((mtype_reg == mfep_pkg::STAT_SYSF0)
                                           ? mfep_pkg::KIND_SYSF0 : mfep_pkg::KIND_SYSF7);
                                    rec.subtype = mtype_reg;
                                    rec.payload_length = vsat;
                                    if (vsat == 28'd0)
                                        phase_next = mfep_pkg::PH_DELTA;
                                    else
                                    begin
                                        rec.last_of_event = 1'b0;
                                        pleft_next = vsat;
                                        phase_next = mfep_pkg::PH_PAYLOAD;
                                    end
                                end
                                else if (vsat != 28'(unsigned'(need)))
                                begin
                                    err_next = 1'b1; rec_valid = 1'b1;
                                    rec.record_kind = mfep_pkg::KIND_ERROR;
                                    rec.subtype = mfep_pkg::ERR_META_LEN;
                                    rec.delta_ticks = '0;
                                end
                                else if (need == 4'sd0)
                                begin
                                    rec_valid = 1'b1;
                                    rec.record_kind = mfep_pkg::KIND_META;
                                    rec.subtype = mtype_reg;
                                    phase_next = mfep_pkg::PH_DELTA;
                                end
                                else
                                begin
                                    fpos_next = '0;
                                    fbuf_next = '0;
                                    phase_next = mfep_pkg::PH_META_FIXED;
                                end
                            end
                            else if (vlong)
                            begin
                                err_next = 1'b1; rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_ERROR;
                                rec.subtype = mfep_pkg::ERR_VARINT;
                                rec.delta_ticks = '0;
                            end
                        end
                        mfep_pkg::PH_STATUS:
                        begin
                            if (data_byte == mfep_pkg::STAT_META)
                            begin
                                rsv_next = 1'b0;
                                phase_next = mfep_pkg::PH_META_TYPE;
                            end
                            else if (data_byte == mfep_pkg::STAT_SYSF0 ||
                                     data_byte == mfep_pkg::STAT_SYSF7)
                            begin
                                rsv_next = 1'b0;
                                mtype_next = data_byte;
                                vacc_next = '0;
                                vcnt_next = '0;
                                phase_next = mfep_pkg::PH_SYSEX_LEN;
                            end
                            else if (data_byte >= 8'hf0 || (!data_byte[7] && !rsv_reg))
                            begin
                                err_next = 1'b1; rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_ERROR;
                                rec.subtype = mfep_pkg::ERR_STATUS;
                                rec.delta_ticks = '0;
                            end
                            else if (data_byte[7])
                            begin
                                rstat_next = data_byte;
                                rsv_next = 1'b1;
                                phase_next = mfep_pkg::PH_CH_P1;
                            end
                            else if (ctype == 4'hc || ctype == 4'hd)
                            begin
                                is_chan = 1'b1;
                                p1 = data_byte;
                            end
                            else
                            begin
                                fbuf_next = {40'd0, data_byte};
                                phase_next = mfep_pkg::PH_CH_P2;
                            end
                        end
                        mfep_pkg::PH_CH_P1:
                        begin
                            if (ctype == 4'hc || ctype == 4'hd)
                            begin
                                is_chan = 1'b1;
                                p1 = data_byte;
                            end
                            else
                            begin
                                fbuf_next = {40'd0, data_byte};
                                phase_next = mfep_pkg::PH_CH_P2;
                            end
                        end
                        mfep_pkg::PH_CH_P2:
                        begin
                            is_chan = 1'b1;
                            p1 = fbuf_reg[7:0];
                            p2 = data_byte;
                        end
                        mfep_pkg::PH_META_TYPE:
                        begin
                            mtype_next = data_byte;
                            vacc_next = '0;
                            vcnt_next = '0;
                            phase_next = mfep_pkg::PH_META_LEN;
                        end
                        mfep_pkg::PH_META_FIXED:
                        begin
                            fbuf_next = shifted;
                            fpos_next = pos_inc;
                            if (signed'(pos4) == need)
                            begin
                                rec_valid = 1'b1;
                                rec.record_kind = mfep_pkg::KIND_META;
                                rec.subtype = mtype_reg;
                                phase_next = mfep_pkg::PH_DELTA;
                                vacc_next = '0;
                                vcnt_next = '0;
                                case (mtype_reg)
                                    mfep_pkg::META_SEQ:
                                        rec.value_a = {8'd0, shifted[15:0]};
                                    mfep_pkg::META_CHPFX:
                                        rec.channel_number = shifted[3:0];
                                    mfep_pkg::META_TEMPO:
                                        rec.value_a = shifted[23:0];
                                    mfep_pkg::META_SMPTE:
                                    begin
                                        rec.value_a = {19'd0, shifted[36:32]};
                                        case (shifted[38:37])
                                            2'd0:    rec.value_b = 16'd24;
                                            2'd1:    rec.value_b = 16'd25;
                                            2'd2:    rec.value_b = 16'd29;
                                            default: rec.value_b = 16'd30;
                                        endcase
                                        rec.value_c = {8'd0, shifted[31:24]};
                                        rec.value_d = shifted[23:16];
                                        rec.value_e = shifted[15:0];
                                    end
                                    mfep_pkg::META_TIMESIG:
                                    begin
                                        rec.value_a = {16'd0, shifted[31:24]};
                                        dexp = shifted[23:16];
                                        rec.value_b = (dexp >= 8'd15) ? 16'h8000
                                                    : (16'd1 << dexp[3:0]);
                                        rec.value_c = {8'd0, shifted[15:8]};
                                        rec.value_d = shifted[7:0];
                                    end
                                    default:
                                    begin
                                        rec.value_a = {16'd0, shifted[15:8]};
                                        rec.value_b = {8'd0, shifted[7:0]};
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            // Payload byte records carry no length.
                            rec_valid = 1'b1;
                            rec.record_kind = mfep_pkg::KIND_PAYLOAD;
                            rec.subtype = mtype_reg;
                            rec.value_a = {16'd0, data_byte};
                            pleft_next = pleft_reg - 28'd1;
                            rec.last_of_event = (pleft_next == 28'd0);
                            if (pleft_next == 28'd0)
                            begin
                                phase_next = mfep_pkg::PH_DELTA;
                                vacc_next = '0;
                                vcnt_next = '0;
                            end
                        end
                    endcase

                    if (is_chan)
                    begin
                        rec_valid = 1'b1;
                        rec.record_kind = mfep_pkg::KIND_CHANNEL;
                        rec.channel_number = rstat_reg[3:0];
                        case (ctype)
                            4'h8: rec.subtype = 8'd0;
                            4'h9: rec.subtype = (p2 == 8'd0) ? 8'd0 : 8'd1;
                            4'ha: rec.subtype = 8'd2;
                            4'hb: rec.subtype = 8'd3;
                            4'hc: rec.subtype = 8'd4;
                            4'hd: rec.subtype = 8'd5;
                            default: rec.subtype = 8'd6;
                        endcase
                        if (rec.subtype == 8'd6)
                            rec.value_a = 24'(p1) + (24'(p2) << 7);
                        else
                        begin
                            rec.value_a = {16'd0, p1};
                            if (rec.subtype != 8'd4 && rec.subtype != 8'd5)
                                rec.value_b = {8'd0, p2};
                        end
                        phase_next = mfep_pkg::PH_DELTA;
                        vacc_next = '0;
                        vcnt_next = '0;
                    end

                    if (!err_next && cdec == 32'd0)
                    begin
                        if (phase_next == mfep_pkg::PH_DELTA && vcnt_next == '0)
                        begin
                            tdone_next = tdone_reg + 16'd1;
                            phase_next = (tdone_next == texp_reg) ? mfep_pkg::PH_DONE
                                                                 : mfep_pkg::PH_TRK_ID;
                            fpos_next = '0;
                            fbuf_next = '0;
                        end
                        else
                        begin
                            err_next = 1'b1; rec_valid = 1'b1;
                            rec = '0;
                            rec.record_kind = mfep_pkg::KIND_ERROR;
                            rec.subtype = mfep_pkg::ERR_FRAMING;
                            rec.track_number = tdone_reg;
                            rec.last_of_event = 1'b1;
                        end
                    end
                end
            endcase

            if (final_byte && !err_next)
            begin
                if (phase_next == mfep_pkg::PH_DONE)
                begin
                    phase_next = mfep_pkg::PH_HDR_ID;
                    fpos_next = '0;  vacc_next = '0;  vcnt_next = '0;  cleft_next = '0;
                    rstat_next = '0; rsv_next = 1'b0; texp_next = '0;  tdone_next = '0;
                    pdelta_next = '0; mtype_next = '0; pleft_next = '0; fbuf_next = '0;
                end
                else
                begin
                    err_next = 1'b1; rec_valid = 1'b1;
                    rec = '0;
                    rec.record_kind = mfep_pkg::KIND_ERROR;
                    rec.subtype = mfep_pkg::ERR_FRAMING;
                    rec.track_number = tdone_next;
                    rec.last_of_event = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mfep_pkg::PH_HDR_ID;
            fpos_reg <= '0;  vacc_reg <= '0;  vcnt_reg <= '0;  cleft_reg <= '0;
            rstat_reg <= '0; rsv_reg <= 1'b0; texp_reg <= '0;  tdone_reg <= '0;
            pdelta_reg <= '0; mtype_reg <= '0; pleft_reg <= '0; fbuf_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fpos_reg <= fpos_next;  vacc_reg <= vacc_next;  vcnt_reg <= vcnt_next;
            cleft_reg <= cleft_next; rstat_reg <= rstat_next; rsv_reg <= rsv_next;
            texp_reg <= texp_next;  tdone_reg <= tdone_next; pdelta_reg <= pdelta_next;
            mtype_reg <= mtype_next; pleft_reg <= pleft_next; fbuf_reg <= fbuf_next;
            err_reg <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg) else $error("error flag dropped");
    a_no_rec_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !rec_valid) else $error("record after error");
    a_err_has_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (!err_reg && err_next) |-> (rec_valid && rec.record_kind == mfep_pkg::KIND_ERROR))
        else $error("error without error record");
    a_track_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (in_track && step && !err_reg) |-> (cleft_reg != 32'd0))
        else $error("track byte with no length left");
`endif
endmodule
`default_nettype wire

FILE: rtl/mfep_out_reg.sv
// Output stage: two-entry skid register between the core and the result channel.
`default_nettype none
module mfep_out_reg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  mfep_pkg::rec_t   in_rec,
    output logic             space,
    mfep_out_if.source       out_ch
);
    logic            v0_reg, v1_reg;
    mfep_pkg::rec_t  d0_reg, d1_reg;
    logic            pop;

    assign pop          = v0_reg && out_ch.ready;
    assign out_ch.valid = v0_reg;
    assign out_ch.payload = d0_reg;
    // Accept while the spare slot is free; one record can still land after that.
    assign space        = !v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                v0_reg <= v1_reg || in_valid;
                v1_reg <= v1_reg && in_valid;
            end
            else if (in_valid)
            begin
                v0_reg <= 1'b1;
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            d0_reg <= v1_reg ? d1_reg : in_rec;
            if (v1_reg && in_valid)
                d1_reg <= in_rec;
        end
        else if (in_valid)
        begin
            if (v0_reg)
                d1_reg <= in_rec;
            else
                d0_reg <= in_rec;
        end
    end

`ifndef SYNTHESIS
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg) else $error("skid slot filled out of order");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !pop) |-> !in_valid) else $error("record lost at output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && !out_ch.ready) |=> v0_reg) else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

FILE: rtl/midi_file_event_parser_unit.sv
// Top level: Standard MIDI File byte parser with valid/ready channels.
//
//  channel   dir  payload                            per transaction
//  in_ch     in   data_byte[8], final_byte[1]        one file byte
//  out_ch    out  record (12 fields, see mfep_pkg)   one parsed record
//
// One byte per cycle while the output stage has space: the core updates its
// parse state from each accepted byte in the same cycle and registers at most
// one record into the output stage.
// in_ch.ready drops only when both output slots are full (sink stalled).
// rst_n clears the parse state to "expect MThd"; an error holds until reset.
`default_nettype none
module midi_file_event_parser_unit #(
    parameter int VARINT_MAX_BYTES = mfep_pkg::VARINT_MAX_BYTES_DEF,
    parameter int CHUNK_LEN_BITS   = mfep_pkg::CHUNK_LEN_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfep_in_if.sink     in_ch,
    mfep_out_if.source  out_ch
);
    logic            step;
    logic            space;
    logic            rec_valid;
    mfep_pkg::rec_t  rec;

    // Take a byte whenever the output stage can absorb a record.
    assign in_ch.ready = space;
    assign step        = in_ch.valid && space;

    mfep_core #(
        .VARINT_MAX_BYTES (VARINT_MAX_BYTES),
        .CHUNK_LEN_BITS   (CHUNK_LEN_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_ch.payload.data_byte),
        .final_byte (in_ch.payload.final_byte),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    mfep_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rec_valid),
        .in_rec   (rec),
        .space    (space),
        .out_ch   (out_ch)
    );

`ifndef SYNTHESIS
    a_rec_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> step) else $error("record without input byte");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !space |-> !step) else $error("byte taken while output full");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |=> out_ch.valid) else $error("record not presented");
`endif
endmodule
`default_nettype wire
